// ----- design/lrel_pkg.sv -----
// ----------------------------------------------------------------------------
// lrel_pkg: shared types for the LRU region eviction list
// Opcodes and the command and response beat layouts used by the block,
// its stream interfaces and its checker.
// ----------------------------------------------------------------------------
package lrel_pkg;

    // Width of a region index as it appears on the ports.
    localparam int REGION_W = 10;

    typedef enum logic [1:0] {
        OP_TOUCH = 2'd0,
        OP_TRACK = 2'd1,
        OP_EVICT = 2'd2,
        OP_RESET = 2'd3
    } opcode_t;

    typedef struct packed {
        opcode_t               opcode;
        logic [REGION_W-1:0]   region_index;
    } cmd_item_t;

    typedef struct packed {
        logic                  evicted_valid;
        logic [REGION_W-1:0]   evicted_region;
    } rsp_item_t;

endpackage

// ----- design/lrel_stream_if.sv -----
// ----------------------------------------------------------------------------
// lrel_stream_if: valid/ready stream channel
// Carries one payload beat whenever valid and ready are both high at a
// rising clock edge.
// ----------------------------------------------------------------------------
interface lrel_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );
endinterface

// ----- design/lrel_ram.sv -----
// ----------------------------------------------------------------------------
// lrel_ram: generic simple dual-port RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module lrel_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- design/lru_region_eviction_list.sv -----
// ----------------------------------------------------------------------------
// lru_region_eviction_list: least-recently-used order over cache regions
// Doubly linked list in link memories with head and tail pointers.
// ----------------------------------------------------------------------------
// The block keeps NUM_REGIONS cache regions in least-recently-used order and
// answers every command beat with exactly one response beat. Touch moves a
// tracked region to the head, track links an untracked region at the head,
// evict unlinks the tail and reports it, and reset empties the list. Touch
// and track of a region index at or above NUM_REGIONS are ignored. A touch
// of a tracked region passes the lookup, unlink and push states, a track
// of a new region the lookup and push, an evict of a non-empty list the
// lookup and unlink, and a command that changes nothing at most the lookup.
// The response is loaded into the output register as the block leaves its
// finish state, and that load waits for as long as an earlier response is
// still stalled on the rsp channel. These states come from the link memories:
// each has one write port and a registered read, so the lookup, the unlink
// and the push each need a state of their own. After rst_n is released, and
// after every reset command, the membership memory is swept clear one entry
// a cycle, and no command is taken during the sweep. The output register
// lets the next command be accepted while a response still waits on a
// stalled rsp channel.
// ----------------------------------------------------------------------------
module lru_region_eviction_list #(
    parameter int NUM_REGIONS = 1024
) (
    input  logic          clk,
    input  logic          rst_n,
    lrel_stream_if.sink   cmd,
    lrel_stream_if.source rsp
);
    import lrel_pkg::*;

    // Region address width, link width (one spare code for "no link") and
    // the width used to range-check an incoming index.
    localparam int IW = $clog2(NUM_REGIONS);
    localparam int LW = $clog2(NUM_REGIONS + 1);
    localparam int CW = (IW > REGION_W) ? IW + 1 : REGION_W + 1;

    localparam logic [LW-1:0] LINK_NONE = LW'(NUM_REGIONS);
    localparam logic [IW-1:0] LAST_ADDR = IW'(NUM_REGIONS - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_UNLINK,
        ST_PUSH,
        ST_FINISH
    } state_t;

    state_t          state_reg,     state_next;
    opcode_t         op_reg,        op_next;
    logic [IW-1:0]   addr_reg,      addr_next;
    logic [LW-1:0]   head_reg,      head_next;
    logic [LW-1:0]   tail_reg,      tail_next;
    logic [LW-1:0]   p_reg,         p_next;
    logic [LW-1:0]   n_reg,         n_next;
    logic            hit_reg,       hit_next;
    logic [IW-1:0]   clr_reg,       clr_next;
    logic            out_valid_reg, out_valid_next;
    rsp_item_t       out_item_reg,  out_item_next;

    // Link memory ports. All three memories are read at the same address.
    logic            prev_we,   next_we,   memb_we;
    logic [IW-1:0]   prev_waddr, next_waddr, memb_waddr;
    logic [LW-1:0]   prev_wdata, next_wdata;
    logic [0:0]      memb_wdata;
    logic [LW-1:0]   prev_rdata, next_rdata;
    logic [0:0]      memb_rdata;

    logic            idx_ok;
    logic [LW-1:0]   addr_link;

    assign idx_ok    = CW'(cmd.payload.region_index) < CW'(NUM_REGIONS);
    assign addr_link = LW'(addr_reg);

    assign cmd.ready   = (state_reg == ST_IDLE);
    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_item_reg;

    lrel_ram #(
        .WIDTH (LW),
        .DEPTH (NUM_REGIONS)
    ) u_prev_ram (
        .clk   (clk),
        .we    (prev_we),
        .waddr (prev_waddr),
        .wdata (prev_wdata),
        .raddr (addr_next),
        .rdata (prev_rdata)
    );

    lrel_ram #(
        .WIDTH (LW),
        .DEPTH (NUM_REGIONS)
    ) u_next_ram (
        .clk   (clk),
        .we    (next_we),
        .waddr (next_waddr),
        .wdata (next_wdata),
        .raddr (addr_next),
        .rdata (next_rdata)
    );

    lrel_ram #(
        .WIDTH (1),
        .DEPTH (NUM_REGIONS)
    ) u_memb_ram (
        .clk   (clk),
        .we    (memb_we),
        .waddr (memb_waddr),
        .wdata (memb_wdata),
        .raddr (addr_next),
        .rdata (memb_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        addr_next      = addr_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        p_next         = p_reg;
        n_next         = n_reg;
        hit_next       = hit_reg;
        clr_next       = clr_reg;
        out_item_next  = out_item_reg;
        // A waiting response leaves the output register when it is taken.
        out_valid_next = out_valid_reg && !rsp.ready;

        prev_we    = 1'b0;
        prev_waddr = '0;
        prev_wdata = '0;
        next_we    = 1'b0;
        next_waddr = '0;
        next_wdata = '0;
        memb_we    = 1'b0;
        memb_waddr = '0;
        memb_wdata = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                // Sweep the membership memory; the links of a region that
                // is not a member are never used, so they need no sweep.
                memb_we    = 1'b1;
                memb_waddr = clr_reg;
                memb_wdata = 1'b0;
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == LAST_ADDR)
                begin
                    clr_next   = '0;
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    op_next   = cmd.payload.opcode;
                    addr_next = IW'(cmd.payload.region_index);
                    hit_next  = 1'b0;
                    unique case (cmd.payload.opcode) inside
                        OP_TOUCH, OP_TRACK:
                        begin
                            state_next = idx_ok ? ST_LOOKUP : ST_FINISH;
                        end
                        OP_EVICT:
                        begin
                            // The victim is the tail; read its links.
                            addr_next  = tail_reg[IW-1:0];
                            state_next = (tail_reg < LINK_NONE) ? ST_LOOKUP
                                                                : ST_FINISH;
                        end
                        OP_RESET:
                        begin
                            head_next  = LINK_NONE;
                            tail_next  = LINK_NONE;
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end

            ST_LOOKUP:
            begin
                // The head's prev link is taken as "no link" without relying
                // on what the memory holds for it.
                p_next = (head_reg == addr_link) ? LINK_NONE : prev_rdata;
                n_next = next_rdata;
                unique case (op_reg)
                    OP_TOUCH: state_next = memb_rdata[0] ? ST_UNLINK : ST_FINISH;
                    OP_TRACK: state_next = memb_rdata[0] ? ST_FINISH : ST_PUSH;
                    OP_EVICT: state_next = ST_UNLINK;
                    OP_RESET: state_next = ST_FINISH;
                endcase
            end

            ST_UNLINK:
            begin
                // Splice the region out: neighbors point past it, or the
                // head and tail pointers move when it sits at an end.
                if (tail_reg == addr_link)
                begin
                    tail_next = p_reg;
                end
                else if (n_reg < LINK_NONE)
                begin
                    prev_we    = 1'b1;
                    prev_waddr = n_reg[IW-1:0];
                    prev_wdata = p_reg;
                end

                if (head_reg == addr_link)
                begin
                    head_next = n_reg;
                end
                else if (p_reg < LINK_NONE)
                begin
                    next_we    = 1'b1;
                    next_waddr = p_reg[IW-1:0];
                    next_wdata = n_reg;
                end

                if (op_reg == OP_EVICT)
                begin
                    memb_we    = 1'b1;
                    memb_waddr = addr_reg;
                    memb_wdata = 1'b0;
                    hit_next   = 1'b1;
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_PUSH;
                end
            end

            ST_PUSH:
            begin
                // Link the region in front of the current head.
                if (head_reg < LINK_NONE)
                begin
                    prev_we    = 1'b1;
                    prev_waddr = head_reg[IW-1:0];
                    prev_wdata = addr_link;
                end
                next_we    = 1'b1;
                next_waddr = addr_reg;
                next_wdata = head_reg;
                memb_we    = 1'b1;
                memb_waddr = addr_reg;
                memb_wdata = 1'b1;
                head_next  = addr_link;
                if (!(tail_reg < LINK_NONE))
                begin
                    tail_next = addr_link;
                end
                state_next = ST_FINISH;
            end

            ST_FINISH:
            begin
                // Hold here until the output register is free.
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next               = 1'b1;
                    out_item_next.evicted_valid  = hit_reg;
                    out_item_next.evicted_region = hit_reg ? REGION_W'(addr_reg) : '0;
                    state_next = (op_reg == OP_RESET) ? ST_CLEAR : ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            op_reg        <= OP_TOUCH;
            addr_reg      <= '0;
            head_reg      <= LINK_NONE;
            tail_reg      <= LINK_NONE;
            p_reg         <= LINK_NONE;
            n_reg         <= LINK_NONE;
            hit_reg       <= 1'b0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_item_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            addr_reg      <= addr_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            p_reg         <= p_next;
            n_reg         <= n_next;
            hit_reg       <= hit_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            out_item_reg  <= out_item_next;
        end
    end
endmodule

// ----- design/lrel_checker.sv -----
// ----------------------------------------------------------------------------
// lrel_checker: port-level checks for the LRU region eviction list
// Watches the command and response channels and is bound to the top level.
// ----------------------------------------------------------------------------
module lrel_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          cmd_valid,
    input logic                          cmd_ready,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic                          rsp_evicted_valid,
    input logic [lrel_pkg::REGION_W-1:0] rsp_evicted_region
);
    import lrel_pkg::*;

    // A stalled response beat stays offered.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response beat dropped while stalled");

    // A stalled response beat keeps its payload.
    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=>
            $stable(rsp_evicted_valid) && $stable(rsp_evicted_region))
        else $error("response payload changed while stalled");

    // One command at a time: the block is busy right after an accept.
    a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("command accepted in back-to-back cycles");

    // A response without an eviction carries region zero.
    a_no_region_without_evict: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_evicted_valid |-> rsp_evicted_region == '0)
        else $error("region reported without an eviction");
endmodule

bind lru_region_eviction_list lrel_checker u_lrel_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd_valid          (cmd.valid),
    .cmd_ready          (cmd.ready),
    .rsp_valid          (rsp.valid),
    .rsp_ready          (rsp.ready),
    .rsp_evicted_valid  (rsp.payload.evicted_valid),
    .rsp_evicted_region (rsp.payload.evicted_region)
);
